// ===== src/wpf_pkg.sv =====
// wpf_pkg: types, constants and the arctangent table shared by the
// waypoint follower modules. No dependencies.
package wpf_pkg;

   // register map of the configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ARRIVAL_RADIUS = 1'b0,
      REG_DRIVE_SPEED    = 1'b1
   } csr_index_type;

   // item actions
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_ODOM = 1'b1;

   // CORDIC sizing
   localparam int ATAN_LEN = 24;                 // entries in the arctangent table
   localparam int ATAN_W   = 24;                 // table entries are below 2^24
   localparam int STEP_W   = $clog2(ATAN_LEN);
   localparam int CX_W     = 62;                 // x/y: 33-bit vector << 26 plus growth
   localparam int CX_FRAC  = 26;
   localparam int Z_W      = 28;                 // angle accumulator, Q24 signed
   localparam int RND_SH   = 11;                 // Q24 -> Q13

   localparam logic signed [Z_W-1:0] ANG_PI    = 28'sd52707179;
   localparam logic signed [Z_W-1:0] ANG_HALF  = 28'sd1024;
   localparam int                    ANG_LIMIT = 25736;

   localparam int RADIUS_RESET = 91750;          // 1.4 m in Q16.16
   localparam int SPEED_RESET  = 256;            // 1.0 in Q8.8

   typedef struct packed {
      logic               action;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] steer_angle;
      logic        [15:0] speed;
      logic        [5:0]  target_index;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_CHECK,
      ST_DIFF,
      ST_MAG,
      ST_SQX,
      ST_SQY,
      ST_SQR,
      ST_SUM,
      ST_CMP,
      ST_ITER,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic              load;
      logic              add;
      logic              diff;
      logic              mag;
      logic              sq_x;
      logic              sq_y;
      logic              sq_r;
      logic              sum;
      logic              cordic_init;
      logic              cordic_step;
      logic [STEP_W-1:0] step_idx;
      logic              advance;
      logic              emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic have_target;
      logic reached;
   } status_type;

   // atan(2^-i) in Q24, rounded
   function automatic logic [ATAN_W-1:0] atan_q24(input logic [STEP_W-1:0] i);
      logic [ATAN_W-1:0] v;
      unique case (i)
         5'd0:    v = 24'd13176795;
         5'd1:    v = 24'd7778716;
         5'd2:    v = 24'd4110060;
         5'd3:    v = 24'd2086331;
         5'd4:    v = 24'd1047214;
         5'd5:    v = 24'd524117;
         5'd6:    v = 24'd262123;
         5'd7:    v = 24'd131069;
         5'd8:    v = 24'd65536;
         5'd9:    v = 24'd32768;
         5'd10:   v = 24'd16384;
         5'd11:   v = 24'd8192;
         5'd12:   v = 24'd4096;
         5'd13:   v = 24'd2048;
         5'd14:   v = 24'd1024;
         5'd15:   v = 24'd512;
         5'd16:   v = 24'd256;
         5'd17:   v = 24'd128;
         5'd18:   v = 24'd64;
         5'd19:   v = 24'd32;
         5'd20:   v = 24'd16;
         5'd21:   v = 24'd8;
         5'd22:   v = 24'd4;
         5'd23:   v = 24'd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/wpf_ram.sv =====
// wpf_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module wpf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/wpf_ctrl.sv =====
// wpf_ctrl: sequencer for the waypoint follower; issues datapath commands.
// Depends on wpf_pkg.
module wpf_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_action,
   input  wpf_pkg::status_type status,
   output wpf_pkg::cmd_type    cmd,
   output logic                busy
);
   import wpf_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.step_idx = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_action == ACT_ODOM) ? ST_CHECK : ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CHECK: begin
            // RAM read of the target is in flight
            state_in = status.have_target ? ST_DIFF : ST_IDLE;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            cmd.sq_r = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.reached) begin
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.cordic_init = 1'b1;
               step_in         = '0;
               state_in        = ST_ITER;
            end
         end
         ST_ITER: begin
            cmd.cordic_step = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_OUT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_OUT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_out_after_iter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> ($past(state_ff) == ST_ITER))
      else $error("result stage entered without CORDIC iterations");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (step_ff <= LAST_STEP))
      else $error("CORDIC step counter out of range");

endmodule

// ===== src/wpf_dp.sv =====
// wpf_dp: datapath of the waypoint follower: registers, waypoint store,
// distance check with a shared squarer, iterative CORDIC and output register.
// Depends on wpf_pkg and wpf_ram.
module wpf_dp #(
   parameter int MAX_WAYPOINTS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [wpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wpf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wpf_pkg::req_type               req_data,
   input  wpf_pkg::cmd_type               cmd,
   output wpf_pkg::status_type            status,
   output logic                           rsp_valid,
   output wpf_pkg::rsp_type               rsp_data
);
   import wpf_pkg::*;

   localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);
   localparam int ADDR_W = $clog2(MAX_WAYPOINTS);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WAYPOINTS);

   // configuration
   logic [30:0] radius_ff, radius_in;
   logic [15:0] speed_ff, speed_in;

   // state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             ovf_ff, ovf_in;

   // working registers
   req_type                 req_ff, req_in;
   logic signed [32:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic        [31:0]      ax_ff, ax_in, ay_ff, ay_in;
   logic                    zero_ff, zero_in;
   logic        [63:0]      sqx_ff, sqx_in, sqy_ff, sqy_in, r2_ff, r2_in;
   logic        [64:0]      sum_ff, sum_in;
   logic signed [CX_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [Z_W-1:0]   cz_ff, cz_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // combinational helpers
   logic                    room;
   logic [63:0]             wp_rdata;
   logic signed [31:0]      wp_x, wp_y;
   logic [32:0]             ndx, ndy;
   logic [31:0]             mul_a;
   logic [63:0]             mul_p;
   logic signed [32:0]      x0, y0;
   logic signed [CX_W-1:0]  xs, ys;
   logic signed [Z_W-1:0]   at;
   logic signed [Z_W:0]     zr;
   logic signed [Z_W:0]     ang;
   logic signed [15:0]      ang_sat;
   logic [CNT_W+5:0]        ptr_wide;

   assign room = (count_ff < CNT_MAX);

   wpf_ram #(
      .WIDTH (64),
      .DEPTH (MAX_WAYPOINTS)
   ) u_store (
      .clock (clock),
      .we    (cmd.add && room),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata ({req_ff.pos_x, req_ff.pos_y}),
      .raddr (ptr_ff[ADDR_W-1:0]),
      .rdata (wp_rdata)
   );

   assign wp_x = wp_rdata[63:32];
   assign wp_y = wp_rdata[31:0];

   // one squarer shared by dx^2, dy^2 and radius^2
   always_comb begin
      priority if (cmd.sq_y) begin
         mul_a = ay_ff;
      end else if (cmd.sq_r) begin
         mul_a = {1'b0, radius_ff};
      end else begin
         mul_a = ax_ff;
      end
      mul_p = 64'(mul_a) * 64'(mul_a);
   end

   assign ndx = -dx_ff;
   assign ndy = -dy_ff;

   // CORDIC step operands
   assign xs = cx_ff >>> cmd.step_idx;
   assign ys = cy_ff >>> cmd.step_idx;
   assign at = Z_W'(atan_q24(cmd.step_idx));

   // Q24 -> Q13 with round half up, then clamp to +-pi
   assign zr  = (Z_W + 1)'(cz_ff) + (Z_W + 1)'(ANG_HALF);
   assign ang = zr >>> RND_SH;
   always_comb begin
      priority if (ang > (Z_W + 1)'(ANG_LIMIT)) begin
         ang_sat = 16'(ANG_LIMIT);
      end else if (ang < -((Z_W + 1)'(ANG_LIMIT))) begin
         ang_sat = -16'(ANG_LIMIT);
      end else begin
         ang_sat = ang[15:0];
      end
   end

   assign ptr_wide = (CNT_W + 6)'(ptr_ff);

   always_comb begin
      radius_in    = radius_ff;
      speed_in     = speed_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      ovf_in       = ovf_ff;
      req_in       = req_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      zero_in      = zero_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      r2_in        = r2_ff;
      sum_in       = sum_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      x0           = dx_ff[32] ? $signed(ndx) : dx_ff;
      y0           = dx_ff[32] ? $signed(ndy) : dy_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_ARRIVAL_RADIUS: radius_in = csr_wdata[30:0];
            REG_DRIVE_SPEED:    speed_in  = csr_wdata[15:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         req_in = req_data;
      end
      if (cmd.add) begin
         if (room) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.diff) begin
         dx_in = {wp_x[31], wp_x} - {req_ff.pos_x[31], req_ff.pos_x};
         dy_in = {wp_y[31], wp_y} - {req_ff.pos_y[31], req_ff.pos_y};
      end
      if (cmd.mag) begin
         ax_in   = dx_ff[32] ? ndx[31:0] : dx_ff[31:0];
         ay_in   = dy_ff[32] ? ndy[31:0] : dy_ff[31:0];
         zero_in = (dx_ff == '0) && (dy_ff == '0);
      end
      if (cmd.sq_x) begin
         sqx_in = mul_p;
      end
      if (cmd.sq_y) begin
         sqy_in = mul_p;
      end
      if (cmd.sq_r) begin
         r2_in = mul_p;
      end
      if (cmd.sum) begin
         sum_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      end
      if (cmd.advance) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (cmd.cordic_init) begin
         // left half-plane: rotate by pi first
         cx_in = CX_W'(x0) <<< CX_FRAC;
         cy_in = CX_W'(y0) <<< CX_FRAC;
         if (dx_ff[32]) begin
            cz_in = dy_ff[32] ? -ANG_PI : ANG_PI;
         end else begin
            cz_in = '0;
         end
      end
      if (cmd.cordic_step) begin
         if (!cy_ff[CX_W-1]) begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            cz_in = cz_ff + at;
         end else begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            cz_in = cz_ff - at;
         end
      end
      if (cmd.emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.steer_angle  = zero_ff ? '0 : ang_sat;
         rsp_in.speed        = speed_ff;
         rsp_in.target_index = ptr_wide[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= 31'(RADIUS_RESET);
         speed_ff     <= 16'(SPEED_RESET);
         count_ff     <= '0;
         ptr_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_in;
         speed_ff     <= speed_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      zero_ff <= zero_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      r2_ff   <= r2_in;
      sum_ff  <= sum_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      rsp_ff  <= rsp_in;
   end

   // carry out of the sum means far away
   assign status.have_target = (ptr_ff < count_ff);
   assign status.reached     = !sum_ff[64] && (sum_ff[63:0] < r2_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_ptr_le_count: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("target pointer passed the waypoint count");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_MAX))
      else $error("overflow flagged while store not full");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

endmodule

// ===== src/waypoint_follow_steering.sv =====
// waypoint_follow_steering: top level of the waypoint follower.
// Depends on wpf_pkg, wpf_ctrl, wpf_dp (and through it wpf_ram).
//
//   channel   ports                           transfer when
//   --------  ------------------------------  ------------------------
//   request   start, busy, req_data           start && !busy
//   result    rsp_valid, rsp_data             rsp_valid (one cycle)
//   config    csr_we, csr_index, csr_wdata    csr_we
//
// Sequence: an add item visits ST_ADD only. An odometry item with no target
// left ends after ST_CHECK, one that reaches its waypoint runs ST_CHECK
// through ST_CMP, and one that steers adds the CORDIC loop and ST_OUT. The
// loop does one step per cycle, and the shared squarer forms three squares.
// The result strobe rises in the first cycle busy is low again.
// Reset is synchronous, active high; it clears the waypoint count, the
// target pointer and the overflow flag and loads the register defaults.
// The waypoint store itself is not cleared; only written entries are read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module waypoint_follow_steering #(
   parameter int MAX_WAYPOINTS = 64,
   parameter int CORDIC_STEPS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           start,
   output logic                           busy,
   input  wpf_pkg::req_type               req_data,
   // result
   output logic                           rsp_valid,
   output wpf_pkg::rsp_type               rsp_data,
   // configuration
   input  logic                           csr_we,
   input  logic [wpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wpf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wpf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: walks fetch, distance check, CORDIC and result stages
   wpf_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_data.action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // datapath: store, squarer, CORDIC and the result register
   wpf_dp #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
